// ===== sv/stp_pkg.sv =====
// Shared types, widths and codes for the trapezoidal stepper pulse generator.
package stp_pkg;

    localparam int STEP_COUNT_WIDTH = 24;
    localparam int FREQ_WIDTH       = 19;
    localparam int RAMP_WIDTH       = 16;
    localparam int PROD_WIDTH       = FREQ_WIDTH + RAMP_WIDTH;
    localparam int CMP_WIDTH        = (STEP_COUNT_WIDTH > RAMP_WIDTH) ?
                                      STEP_COUNT_WIDTH : RAMP_WIDTH;
    localparam int DIV_STEPS        = FREQ_WIDTH;
    localparam int DIV_CNT_WIDTH    = $clog2(DIV_STEPS);

    localparam int IN_FIELD_BITS    = STEP_COUNT_WIDTH + FREQ_WIDTH + 1;
    localparam int IN_DATA_WIDTH    = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS   = 3 + STEP_COUNT_WIDTH;
    localparam int OUT_DATA_WIDTH   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH   = FREQ_WIDTH;

    localparam logic [FREQ_WIDTH-1:0] HALF_PERIOD_NUM = FREQ_WIDTH'(500000);
    localparam logic [FREQ_WIDTH-1:0] BASE_FREQ_RESET = FREQ_WIDTH'(150);
    localparam logic [RAMP_WIDTH-1:0] RAMP_LEN_RESET  = RAMP_WIDTH'(150);

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BASE_FREQ = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RAMP_LEN  = 1'b1;

    // Input item kinds carried on tuser.
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // Request to the shared divider.
    typedef struct packed {
        logic                  start;
        logic [FREQ_WIDTH-1:0] rem_init;
        logic [FREQ_WIDTH-1:0] dividend;
        logic [FREQ_WIDTH-1:0] divisor;
    } div_req_t;

    // Answer from the shared divider.
    typedef struct packed {
        logic                  done;
        logic [FREQ_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/stp_div.sv =====
// Shared restoring divider that retires one quotient bit per clock cycle.
module stp_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  stp_pkg::div_req_t req,
    output stp_pkg::div_rsp_t rsp
);
    import stp_pkg::*;

    logic [FREQ_WIDTH-1:0]    rem_reg, rem_next;
    logic [FREQ_WIDTH-1:0]    quo_reg, quo_next;
    logic [FREQ_WIDTH-1:0]    den_reg, den_next;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [FREQ_WIDTH:0]      trial;
    logic [FREQ_WIDTH:0]      diff;

    // The remainder always stays below the divisor, so one extra bit suffices.
    assign trial = {rem_reg, quo_reg[FREQ_WIDTH-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.rem_init;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[FREQ_WIDTH])
            begin
                rem_next = diff[FREQ_WIDTH-1:0];
                quo_next = {quo_reg[FREQ_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[FREQ_WIDTH-1:0];
                quo_next = {quo_reg[FREQ_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_WIDTH'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sv/stepper_trapezoid_pulse_gen.sv =====
// Top level of the trapezoidal stepper step and direction pulse generator.
//
// Input items arrive on the s_axis channel. tuser selects the kind: a tick
// item stands for one microsecond of motor time, a start item loads a move
// (step count, peak frequency and direction from tdata). Every accepted item
// yields exactly one result transfer on m_axis carrying the step pin level,
// the direction pin level, the busy flag and the count of completed steps.
// Most items need no wait: the result register is loaded at the edge
// of the input transfer and the result is offered in the next cycle. An item
// that begins a new step (a start, or the tick that ends a low half period)
// first computes the step frequency and half period with one multiplier and
// one shared serial divider, one quotient bit a cycle. Inside a ramp the
// divider runs twice, first for the ramp and then for the half period, and the
// result is loaded when the half period division is done; at the peak frequency
// only the half period division runs. s_axis_tready is low while that runs.
// The user writes the base frequency and ramp length registers through the cfg
// port only while nothing is in flight; the block itself does not enforce it.
// Reset clears the move state and loads both registers with 150. A stalled
// receiver holds the result in the output register; a new item is taken
// in the same cycle the pending result leaves, so no item is ever lost.
module stepper_trapezoid_pulse_gen
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [stp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_addr,
    input  logic [stp_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata,
    // Input items.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: total_steps, max_freq, direction, zero fill.
    input  logic [stp_pkg::IN_DATA_WIDTH-1:0]     s_axis_tdata,
    // tuser: func.
    input  logic                                  s_axis_tuser,
    // Result items.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: pulse_level, dir_level, busy_res, steps_done, zero fill.
    output logic [stp_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata
);
    import stp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RDIV_GO,
        S_RDIV_WAIT,
        S_FREQ,
        S_HDIV_GO,
        S_HDIV_WAIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [FREQ_WIDTH-1:0]       base_freq_reg, base_freq_next;
    logic [RAMP_WIDTH-1:0]       ramp_len_reg, ramp_len_next;
    logic                        moving_reg, moving_next;
    logic                        dir_reg, dir_next;
    logic [STEP_COUNT_WIDTH-1:0] step_index_reg, step_index_next;
    logic [STEP_COUNT_WIDTH-1:0] move_length_reg, move_length_next;
    logic [FREQ_WIDTH-1:0]       peak_freq_reg, peak_freq_next;
    logic [FREQ_WIDTH-1:0]       half_period_reg, half_period_next;
    logic [FREQ_WIDTH-1:0]       half_counter_reg, half_counter_next;
    logic                        high_phase_reg, high_phase_next;
    logic [PROD_WIDTH-1:0]       prod_reg, prod_next;
    logic                        in_ramp_reg, in_ramp_next;
    logic [FREQ_WIDTH-1:0]       freq_reg, freq_next;
    logic                        out_valid_reg, out_valid_next;
    logic [OUT_DATA_WIDTH-1:0]   out_data_reg, out_data_next;

    logic                        in_xfer;
    logic                        out_xfer;
    logic                        out_load;
    logic [STEP_COUNT_WIDTH-1:0] in_total;
    logic [FREQ_WIDTH-1:0]       in_max_freq;
    logic                        in_direction;
    logic [FREQ_WIDTH-1:0]       hc_dec;
    logic [STEP_COUNT_WIDTH-1:0] idx_inc;
    logic [FREQ_WIDTH-1:0]       span;
    logic [STEP_COUNT_WIDTH-1:0] remaining;
    logic [CMP_WIDTH-1:0]        idx_ext;
    logic [CMP_WIDTH-1:0]        rem_ext;
    logic [CMP_WIDTH-1:0]        ramp_ext;
    logic                        accel;
    logic                        decel;
    logic [RAMP_WIDTH-1:0]       ramp_k;
    logic [FREQ_WIDTH-1:0]       ramp_freq;
    logic [FREQ_WIDTH-1:0]       sel_freq;
    div_req_t                    div_req;
    div_rsp_t                    div_rsp;

    assign in_total     = s_axis_tdata[STEP_COUNT_WIDTH-1:0];
    assign in_max_freq  = s_axis_tdata[STEP_COUNT_WIDTH +: FREQ_WIDTH];
    assign in_direction = s_axis_tdata[STEP_COUNT_WIDTH + FREQ_WIDTH];

    // The output register may be refilled in the cycle its content leaves.
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign hc_dec  = (half_counter_reg != '0) ? (half_counter_reg - FREQ_WIDTH'(1))
                                              : half_counter_reg;
    assign idx_inc = step_index_reg + STEP_COUNT_WIDTH'(1);

    // Ramp selection for the step that is about to begin.
    assign span      = (peak_freq_reg > base_freq_reg) ? (peak_freq_reg - base_freq_reg) : '0;
    assign remaining = move_length_reg - step_index_reg;
    assign idx_ext   = CMP_WIDTH'(step_index_reg);
    assign rem_ext   = CMP_WIDTH'(remaining);
    assign ramp_ext  = CMP_WIDTH'(ramp_len_reg);
    assign accel     = (ramp_len_reg != '0) && (idx_ext < ramp_ext);
    assign decel     = (ramp_len_reg != '0) && (rem_ext < ramp_ext);
    // Within a ramp the step position is below the ramp length, so it fits its width.
    assign ramp_k    = accel ? idx_ext[RAMP_WIDTH-1:0] : rem_ext[RAMP_WIDTH-1:0];

    // The ramp quotient does not exceed the span, so the sum does not exceed the peak.
    assign ramp_freq = base_freq_reg + div_rsp.quotient;
    assign sel_freq  = in_ramp_reg ? ramp_freq : peak_freq_reg;

    // The product over 2^19 stays below the ramp length, so its upper part is
    // the starting remainder and the divider only has 19 quotient bits to find.
    always_comb
    begin
        div_req.start = (state_reg == S_RDIV_GO) || (state_reg == S_HDIV_GO);
        if (state_reg == S_RDIV_GO)
        begin
            div_req.rem_init = {{(FREQ_WIDTH-RAMP_WIDTH){1'b0}},
                                prod_reg[PROD_WIDTH-1:FREQ_WIDTH]};
            div_req.dividend = prod_reg[FREQ_WIDTH-1:0];
            div_req.divisor  = {{(FREQ_WIDTH-RAMP_WIDTH){1'b0}}, ramp_len_reg};
        end
        else
        begin
            div_req.rem_init = '0;
            div_req.dividend = HALF_PERIOD_NUM;
            div_req.divisor  = freq_reg;
        end
    end

    stp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next        = state_reg;
        base_freq_next    = base_freq_reg;
        ramp_len_next     = ramp_len_reg;
        moving_next       = moving_reg;
        dir_next          = dir_reg;
        step_index_next   = step_index_reg;
        move_length_next  = move_length_reg;
        peak_freq_next    = peak_freq_reg;
        half_period_next  = half_period_reg;
        half_counter_next = half_counter_reg;
        high_phase_next   = high_phase_reg;
        prod_next         = prod_reg;
        in_ramp_next      = in_ramp_reg;
        freq_next         = freq_reg;
        out_load          = 1'b0;

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_BASE_FREQ: base_freq_next = cfg_wdata;
                CFG_RAMP_LEN:  ramp_len_next  = cfg_wdata[RAMP_WIDTH-1:0];
                default:       base_freq_next = base_freq_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    out_load = 1'b1;
                    if (s_axis_tuser == FUNC_START)
                    begin
                        // A start during a move is dropped and only reports state.
                        if (!moving_reg)
                        begin
                            move_length_next = in_total;
                            peak_freq_next   = (in_max_freq < base_freq_reg) ?
                                               base_freq_reg : in_max_freq;
                            dir_next         = in_direction;
                            step_index_next  = '0;
                            if (in_total != '0)
                            begin
                                moving_next = 1'b1;
                                out_load    = 1'b0;
                                state_next  = S_MUL;
                            end
                            else
                            begin
                                high_phase_next   = 1'b0;
                                half_counter_next = '0;
                            end
                        end
                    end
                    else if (moving_reg)
                    begin
                        half_counter_next = hc_dec;
                        if (hc_dec == '0)
                        begin
                            if (high_phase_reg)
                            begin
                                high_phase_next   = 1'b0;
                                half_counter_next = half_period_reg;
                            end
                            else
                            begin
                                step_index_next = idx_inc;
                                if (idx_inc >= move_length_reg)
                                begin
                                    moving_next     = 1'b0;
                                    high_phase_next = 1'b0;
                                end
                                else
                                begin
                                    out_load   = 1'b0;
                                    state_next = S_MUL;
                                end
                            end
                        end
                    end
                end
            end
            S_MUL:
            begin
                prod_next    = PROD_WIDTH'(span) * PROD_WIDTH'(ramp_k);
                in_ramp_next = accel || decel;
                state_next   = (accel || decel) ? S_RDIV_GO : S_FREQ;
            end
            S_RDIV_GO:
            begin
                state_next = S_RDIV_WAIT;
            end
            S_RDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FREQ;
                end
            end
            S_FREQ:
            begin
                // A zero frequency counts as 1 Hz.
                freq_next  = (sel_freq == '0) ? FREQ_WIDTH'(1) : sel_freq;
                state_next = S_HDIV_GO;
            end
            S_HDIV_GO:
            begin
                state_next = S_HDIV_WAIT;
            end
            S_HDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // Frequencies above the numerator still get a one tick half period.
                    half_period_next  = (div_rsp.quotient == '0) ? FREQ_WIDTH'(1)
                                                                 : div_rsp.quotient;
                    half_counter_next = half_period_next;
                    high_phase_next   = 1'b1;
                    out_load          = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_xfer ? 1'b0 : out_valid_reg);
        out_data_next  = out_load ?
                         OUT_DATA_WIDTH'({step_index_next, moving_next, dir_next,
                                          high_phase_next}) :
                         out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            base_freq_reg    <= BASE_FREQ_RESET;
            ramp_len_reg     <= RAMP_LEN_RESET;
            moving_reg       <= 1'b0;
            dir_reg          <= 1'b0;
            step_index_reg   <= '0;
            move_length_reg  <= '0;
            peak_freq_reg    <= '0;
            half_period_reg  <= '0;
            half_counter_reg <= '0;
            high_phase_reg   <= 1'b0;
            prod_reg         <= '0;
            in_ramp_reg      <= 1'b0;
            freq_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            base_freq_reg    <= base_freq_next;
            ramp_len_reg     <= ramp_len_next;
            moving_reg       <= moving_next;
            dir_reg          <= dir_next;
            step_index_reg   <= step_index_next;
            move_length_reg  <= move_length_next;
            peak_freq_reg    <= peak_freq_next;
            half_period_reg  <= half_period_next;
            half_counter_reg <= half_counter_next;
            high_phase_reg   <= high_phase_next;
            prod_reg         <= prod_next;
            in_ramp_reg      <= in_ramp_next;
            freq_reg         <= freq_next;
            out_valid_reg    <= out_valid_next;
            out_data_reg     <= out_data_next;
        end
    end

endmodule
